>>> hw/rtl/ftwa_pkg.sv
// Shared constants for the frame time window averaging block.
package ftwa_pkg;

    localparam int WINDOW    = 60;
    localparam int TIME_BITS = 20;
    localparam int PTR_W     = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = TIME_BITS + $clog2(WINDOW);
    localparam int RATE_W    = 24;
    localparam int DIV_W     = CNT_W + RATE_W;
    localparam int DVR_W     = SUM_W;
    localparam int ITER_W    = $clog2(DIV_W);

    localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(16000000);

endpackage

>>> hw/rtl/frame_time_window_average_top.sv
// Frame time window averaging: instantaneous and windowed frame time and rate.
//
// Each transaction carries one frame duration in microseconds. The duration is
// stored in a 60-entry history ring whose entries read as zero after reset
// (per-entry valid bits, no clearing pass), and a running sum and count of the
// nonzero entries are kept. One result follows each transaction: the echoed
// duration, the instantaneous rate in 1/16 fps, the window's mean frame time
// and mean rate. All three quotients come from one shared restoring divider
// that produces one quotient bit per cycle (24, 26 and 30 bits). After
// acceptance the block steps through the window update, the rate division,
// the two average divisions and the result state; a zero duration skips the
// rate division and an empty window skips the two average divisions as well.
// The block accepts no new item until the result has been taken.
module frame_time_window_average_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ftwa_pkg::TIME_BITS-1:0] i_delta_us,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ftwa_pkg::TIME_BITS-1:0] o_frame_time_us,
    output logic [ftwa_pkg::RATE_W-1:0]    o_fps_now_q4,
    output logic [ftwa_pkg::TIME_BITS-1:0] o_avg_frame_time_us,
    output logic [ftwa_pkg::RATE_W-1:0]    o_avg_fps_q4,
    output logic [5:0]                    o_samples_counted,
    output logic                          o_zero_delta
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_ADD,
        S_CHK,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_FPS,
        OP_AVGT,
        OP_AVGF
    } t_op;

    localparam int TB  = ftwa_pkg::TIME_BITS;
    localparam int DW  = ftwa_pkg::DIV_W;
    localparam int VW  = ftwa_pkg::DVR_W;
    localparam int RW  = ftwa_pkg::RATE_W;
    localparam int SW  = ftwa_pkg::SUM_W;
    localparam int CW  = ftwa_pkg::CNT_W;
    localparam int PW  = ftwa_pkg::PTR_W;
    localparam int IW  = ftwa_pkg::ITER_W;

    t_state                   r_state, n_state;
    t_op                      r_op, n_op;
    logic [ftwa_pkg::WINDOW-1:0] r_vld;
    logic [PW-1:0]            r_wp;
    logic [SW-1:0]            r_sum, n_sum;
    logic [CW-1:0]            r_count, n_count;
    logic [TB-1:0]            r_d;
    logic [TB-1:0]            r_rd;
    logic                     r_rd_vld;
    logic [DW-1:0]            r_quo, n_quo;
    logic [VW-1:0]            r_rem, n_rem;
    logic [VW-1:0]            r_dvr, n_dvr;
    logic [IW-1:0]            r_iter, n_iter;
    logic [DW-1:0]            r_prod, n_prod;
    logic [RW-1:0]            r_fps, n_fps;
    logic [TB-1:0]            r_avgt, n_avgt;
    logic [RW-1:0]            r_avgf, n_avgf;

    logic [TB-1:0]            r_mem [ftwa_pkg::WINDOW];

    logic                     w_in_acc;
    logic [TB-1:0]            w_old;
    logic [VW:0]              w_shift;
    logic [VW:0]              w_diff;
    logic                     w_ge;
    logic [DW-1:0]            w_qnext;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);
    assign w_old    = r_rd_vld ? r_rd : '0;

    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvr};
    assign w_ge    = (w_shift >= {1'b0, r_dvr});
    assign w_qnext = {r_quo[DW-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rd         <= r_mem[r_wp];
            r_mem[r_wp]  <= i_delta_us;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sum   = r_sum;
        n_count = r_count;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvr   = r_dvr;
        n_iter  = r_iter;
        n_prod  = r_prod;
        n_fps   = r_fps;
        n_avgt  = r_avgt;
        n_avgf  = r_avgf;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (w_old != '0) begin
                    n_sum   = r_sum - SW'(w_old);
                    n_count = r_count - CW'(1);
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_d != '0) begin
                    n_sum   = r_sum + SW'(r_d);
                    n_count = r_count + CW'(1);
                    n_quo   = {ftwa_pkg::RATE_SCALE, {(DW-RW){1'b0}}};
                    n_rem   = '0;
                    n_dvr   = VW'(r_d);
                    n_iter  = IW'(RW - 1);
                    n_op    = OP_FPS;
                    n_state = S_DIV;
                end else begin
                    n_fps   = ftwa_pkg::RATE_SCALE;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_count == '0) begin
                    n_avgt  = '0;
                    n_avgf  = '0;
                    n_state = S_OUT;
                end else begin
                    n_quo   = {r_sum, {(DW-SW){1'b0}}};
                    n_rem   = '0;
                    n_dvr   = VW'(r_count);
                    n_iter  = IW'(SW - 1);
                    n_op    = OP_AVGT;
                    n_prod  = {{RW{1'b0}}, r_count} * {{CW{1'b0}}, ftwa_pkg::RATE_SCALE};
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = w_qnext;
                n_rem = w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
                if (r_iter == '0) begin
                    unique case (r_op)
                        OP_FPS: begin
                            n_fps   = w_qnext[RW-1:0];
                            n_state = S_CHK;
                        end
                        OP_AVGT: begin
                            n_avgt = w_qnext[TB-1:0];
                            n_quo  = r_prod;
                            n_rem  = '0;
                            n_dvr  = r_sum;
                            n_iter = IW'(DW - 1);
                            n_op   = OP_AVGF;
                        end
                        OP_AVGF: begin
                            n_avgf  = w_qnext[RW-1:0];
                            n_state = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end else begin
                    n_iter = r_iter - IW'(1);
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_FPS;
            r_vld   <= '0;
            r_wp    <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_sum   <= n_sum;
            r_count <= n_count;
            if (w_in_acc) begin
                r_rd_vld    <= r_vld[r_wp];
                r_vld[r_wp] <= 1'b1;
                r_d         <= i_delta_us;
                r_wp        <= (r_wp == PW'(ftwa_pkg::WINDOW - 1)) ? '0 : r_wp + PW'(1);
            end
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_dvr  <= n_dvr;
            r_iter <= n_iter;
            r_prod <= n_prod;
            r_fps  <= n_fps;
            r_avgt <= n_avgt;
            r_avgf <= n_avgf;
        end
    end

    assign o_in_ready          = (r_state == S_IDLE);
    assign o_out_valid         = (r_state == S_OUT);
    assign o_frame_time_us     = r_d;
    assign o_fps_now_q4        = r_fps;
    assign o_avg_frame_time_us = r_avgt;
    assign o_avg_fps_q4        = r_avgf;
    assign o_samples_counted   = 6'(r_count);
    assign o_zero_delta        = (r_d == '0);

endmodule

>>> hw/rtl/ftwa_checker.sv
// Port-level assertions for the frame time window averaging block, with bind.
module ftwa_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [ftwa_pkg::RATE_W-1:0]    o_fps_now_q4,
    input logic [ftwa_pkg::TIME_BITS-1:0] o_avg_frame_time_us,
    input logic [ftwa_pkg::RATE_W-1:0]    o_avg_fps_q4,
    input logic [5:0]                    o_samples_counted,
    input logic                          o_zero_delta
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fps_now_q4)
            && $stable(o_avg_fps_q4) && $stable(o_avg_frame_time_us))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a transaction");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_delta |-> o_fps_now_q4 == ftwa_pkg::RATE_SCALE)
        else $error("zero duration did not saturate the rate");

    a_empty_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_samples_counted == 6'd0)
            |-> (o_avg_frame_time_us == '0) && (o_avg_fps_q4 == '0))
        else $error("empty window gave nonzero averages");

endmodule

bind frame_time_window_average_top ftwa_assertions u_ftwa_assertions (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_fps_now_q4        (o_fps_now_q4),
    .o_avg_frame_time_us (o_avg_frame_time_us),
    .o_avg_fps_q4        (o_avg_fps_q4),
    .o_samples_counted   (o_samples_counted),
    .o_zero_delta        (o_zero_delta)
);
